@@ rtl/assert_macros.svh @@
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define TLF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define TLF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tlf_pkg.sv @@
package tlf_pkg;

	localparam int LINE_WIDTH = 63;
	localparam int COL_W = $clog2(LINE_WIDTH + 1);
	localparam int ADDR_W = $clog2(LINE_WIDTH);
	localparam logic [COL_W-1:0] LINE_LEN = COL_W'(LINE_WIDTH);

	localparam logic [7:0] CH_BLANK = 8'd32;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_NL = 8'd10;

	localparam logic [1:0] TAB_SHIFT_RST = 2'd2;

	// True when the position lies on a tab stop of spacing 2**sh.
	function automatic logic at_stop(input logic [7:0] p, input logic [1:0] sh);
		logic [7:0] m;
		m = (8'd1 << sh) - 8'd1;
		return (p & m) == 8'd0;
	endfunction

endpackage

@@ rtl/text_line_folder.sv @@
// Text line folder: one text byte per input beat, folded text out.
// Input channel in_valid/in_ready carries char_in. Output channel
// out_valid/out_ready carries char_out and last; last marks the final
// byte caused by one input, which is always the newline ending a line.
// The configuration channel cfg_valid/cfg_ready carries tab_shift (tab
// stops every 2**tab_shift columns); write it only while the block idles.
// The block takes one input at a time and in_ready is low while it works.
// A tab that does not end the line writes one blank to the line buffer
// per cycle until the next tab stop. Emitting a line streams one beat
// per cycle from the buffer's single read port while the receiver is
// ready: len + 1 beats for a line of len bytes. A byte that fills the line
// adds a backward blank search, one buffer read per cycle, and after the
// line is sent the tail is copied to the front at one byte per cycle.
// A stalled receiver simply holds the current beat; the sequencer waits.
// Reset clears the column and restores tab_shift to 2; the line buffer
// needs no clearing, since only written entries are ever read.
module text_line_folder
	import tlf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] tab_shift,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_out,
	output logic       last
);

	typedef enum logic [2:0] {
		IDLE,
		TAB,
		SRCH_RD,
		SRCH_CHK,
		EMIT,
		SHIFT
	} state_t;

	state_t            state_q, state_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [COL_W-1:0]  pos_q, pos_d;
	logic [COL_W-1:0]  rd_q, rd_d;
	logic [COL_W-1:0]  len_q, len_d;
	logic              tail_q, tail_d;
	logic              ovalid_q, ovalid_d;
	logic              nl_q, nl_d;
	logic [1:0]        tab_shift_q;

	logic [7:0]        line_store_q [LINE_WIDTH];
	logic [7:0]        rdata_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;

	logic [COL_W-1:0]  pos_in;
	logic [COL_W-1:0]  pos_p1;
	logic [COL_W-1:0]  rd_inc;
	logic [COL_W-1:0]  pos_inc;
	logic [COL_W-1:0]  cut;
	logic              cut_found;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == IDLE);
	assign out_valid = ovalid_q;
	assign char_out  = nl_q ? CH_NL : rdata_q;
	assign last      = nl_q;

	assign pos_in  = (col_q >= LINE_LEN) ? '0 : col_q;
	assign pos_p1  = pos_in + 1'b1;
	assign rd_inc  = rd_q + 1'b1;
	assign pos_inc = pos_q + 1'b1;

	always_comb begin
		state_d   = state_q;
		col_d     = col_q;
		pos_d     = pos_q;
		rd_d      = rd_q;
		len_d     = len_q;
		tail_d    = tail_q;
		ovalid_d  = ovalid_q;
		nl_d      = nl_q;
		mem_we    = 1'b0;
		mem_waddr = pos_in[ADDR_W-1:0];
		mem_wdata = char_in;
		mem_re    = 1'b0;
		mem_raddr = rd_q[ADDR_W-1:0];
		cut       = LINE_LEN;
		cut_found = 1'b0;

		unique case (state_q)
			IDLE: begin
				if (in_valid) begin
					if (char_in == CH_TAB) begin
						mem_we    = 1'b1;
						mem_wdata = CH_BLANK;
						if (pos_p1 >= LINE_LEN) begin
							col_d  = '0;
							len_d  = LINE_LEN;
							tail_d = 1'b0;
						end else if (!at_stop(8'(pos_p1), tab_shift_q)) begin
							pos_d   = pos_p1;
							state_d = TAB;
						end else begin
							col_d = pos_p1;
						end
					end else if (char_in == CH_NL) begin
						col_d  = '0;
						len_d  = pos_in;
						tail_d = 1'b0;
					end else begin
						mem_we = 1'b1;
						if (pos_p1 >= LINE_LEN) begin
							rd_d    = LINE_LEN - 1'b1;
							state_d = SRCH_RD;
						end else begin
							col_d = pos_p1;
						end
					end
					// A full line after a tab, or a newline on a non-empty line.
					if ((char_in == CH_TAB && pos_p1 >= LINE_LEN) ||
					    (char_in == CH_NL && pos_in != '0)) begin
						mem_re    = 1'b1;
						mem_raddr = '0;
						rd_d      = '0;
						ovalid_d  = 1'b1;
						nl_d      = 1'b0;
						state_d   = EMIT;
					end
				end
			end
			TAB: begin
				mem_waddr = pos_q[ADDR_W-1:0];
				mem_wdata = CH_BLANK;
				if (pos_q < LINE_LEN && !at_stop(8'(pos_q), tab_shift_q)) begin
					mem_we = 1'b1;
					pos_d  = pos_inc;
				end else if (pos_q >= LINE_LEN) begin
					col_d     = '0;
					len_d     = LINE_LEN;
					tail_d    = 1'b0;
					mem_re    = 1'b1;
					mem_raddr = '0;
					rd_d      = '0;
					ovalid_d  = 1'b1;
					nl_d      = 1'b0;
					state_d   = EMIT;
				end else begin
					col_d   = pos_q;
					state_d = IDLE;
				end
			end
			SRCH_RD: begin
				mem_re  = 1'b1;
				state_d = SRCH_CHK;
			end
			SRCH_CHK: begin
				// Column 0 is never a cut point; reaching it means a hard cut.
				if (rdata_q == CH_BLANK) begin
					cut       = rd_inc;
					cut_found = 1'b1;
				end else if (rd_q == COL_W'(1)) begin
					cut       = LINE_LEN;
					cut_found = 1'b1;
				end else begin
					rd_d      = rd_q - 1'b1;
					mem_re    = 1'b1;
					mem_raddr = rd_d[ADDR_W-1:0];
				end
				if (cut_found) begin
					len_d     = cut;
					tail_d    = (cut < LINE_LEN);
					col_d     = (cut < LINE_LEN) ? LINE_LEN - cut : '0;
					mem_re    = 1'b1;
					mem_raddr = '0;
					rd_d      = '0;
					ovalid_d  = 1'b1;
					nl_d      = 1'b0;
					state_d   = EMIT;
				end
			end
			EMIT: begin
				if (out_ready) begin
					if (nl_q) begin
						ovalid_d = 1'b0;
						nl_d     = 1'b0;
						if (tail_q) begin
							mem_re    = 1'b1;
							mem_raddr = len_q[ADDR_W-1:0];
							rd_d      = len_q;
							pos_d     = '0;
							state_d   = SHIFT;
						end else begin
							state_d = IDLE;
						end
					end else if (rd_inc < len_q) begin
						rd_d      = rd_inc;
						mem_re    = 1'b1;
						mem_raddr = rd_inc[ADDR_W-1:0];
					end else begin
						nl_d = 1'b1;
					end
				end
			end
			SHIFT: begin
				// Copy the tail to the front, reading ahead of the write.
				mem_we    = 1'b1;
				mem_waddr = pos_q[ADDR_W-1:0];
				mem_wdata = rdata_q;
				pos_d     = pos_inc;
				if (rd_inc < LINE_LEN) begin
					rd_d      = rd_inc;
					mem_re    = 1'b1;
					mem_raddr = rd_inc[ADDR_W-1:0];
				end else begin
					state_d = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			col_q       <= '0;
			pos_q       <= '0;
			rd_q        <= '0;
			len_q       <= '0;
			tail_q      <= 1'b0;
			ovalid_q    <= 1'b0;
			nl_q        <= 1'b0;
			tab_shift_q <= TAB_SHIFT_RST;
		end else begin
			state_q  <= state_d;
			col_q    <= col_d;
			pos_q    <= pos_d;
			rd_q     <= rd_d;
			len_q    <= len_d;
			tail_q   <= tail_d;
			ovalid_q <= ovalid_d;
			nl_q     <= nl_d;
			if (cfg_valid) begin
				tab_shift_q <= tab_shift;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_store_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= line_store_q[mem_raddr];
		end
	end

endmodule

@@ rtl/tlf_checker.sv @@
`include "assert_macros.svh"

module tlf_checker
	import tlf_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] char_out,
	input logic       last
);

	property p_last_nl;
		out_valid && last |-> char_out == CH_NL;
	endproperty

	property p_run_ends;
		out_valid && out_ready && last |=> !out_valid;
	endproperty

	property p_stall_hold;
		out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last);
	endproperty

	// The block never takes a new byte while a beat of the current run is pending.
	`TLF_ASSERT(a_busy_while_out, clk, arst_n, out_valid |-> !in_ready, "input ready during output")

	// Every run ends with the newline that closes the line.
	`TLF_ASSERT(a_last_is_nl, clk, arst_n, p_last_nl, "last beat not newline")

	// Once the newline is taken, the run is over.
	`TLF_ASSERT(a_run_ends, clk, arst_n, p_run_ends, "beat after last")

	// A stalled beat holds.
	`TLF_ASSERT(a_stall_hold, clk, arst_n, p_stall_hold, "stalled beat changed")

	// Nothing is offered while reset is applied.
	`TLF_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !out_valid, "output valid in reset")

endmodule

bind text_line_folder tlf_checker u_tlf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.char_out  (char_out),
	.last      (last)
);

@@ tb/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tlf_pkg::*;

	localparam int DRAIN_CYCLES = 3 * LINE_WIDTH + 16;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PRESSURE_CYCLES = 400;
	localparam int PRESSURE_AFTER_BEATS = 150;
	localparam int ITEMS_PER_PHASE = 100;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} fold_beat_t;

	// Folds the accepted text the same way the block should and keeps the
	// bytes it must send, oldest first.
	class line_fold_predictor;
		logic [7:0] line_buf [LINE_WIDTH];
		int column;
		logic [1:0] tab_sh;
		fold_beat_t folded_text [$];
		fold_beat_t char_run [$];
		int errors;

		function new();
			foreach (line_buf[i])
				line_buf[i] = 8'd0;
			column = 0;
			tab_sh = TAB_SHIFT_RST;
			errors = 0;
		endfunction

		function void set_tab_shift(input logic [1:0] v);
			tab_sh = v;
		endfunction

		function int pending();
			return folded_text.size();
		endfunction

		function void queue_line(input int len);
			for (int i = 0; i < len; i++)
				char_run.push_back('{ch: line_buf[i], last: 1'b0});
			if (len > 0)
				char_run.push_back('{ch: CH_NL, last: 1'b0});
		endfunction

		function void take_char(input logic [7:0] c);
			int pos;
			int p;
			int cut;
			int mask;
			fold_beat_t b;
			pos = column;
			mask = (1 << tab_sh) - 1;
			char_run.delete();
			if (pos >= LINE_WIDTH)
				pos = 0;
			line_buf[pos] = c;
			if (c == CH_TAB) begin
				line_buf[pos] = CH_BLANK;
				pos++;
				while (pos < LINE_WIDTH && (pos & mask) != 0) begin
					line_buf[pos] = CH_BLANK;
					pos++;
				end
				if (pos >= LINE_WIDTH) begin
					queue_line(pos);
					pos = 0;
				end
			end else if (c == CH_NL) begin
				queue_line(pos);
				pos = 0;
			end else begin
				pos++;
				if (pos >= LINE_WIDTH) begin
					// Column 0 is never a cut point; without a blank the line breaks at full width.
					p = LINE_WIDTH - 1;
					while (p > 0 && line_buf[p] != CH_BLANK)
						p--;
					cut = (p == 0) ? LINE_WIDTH : p + 1;
					queue_line(cut);
					pos = 0;
					for (int j = cut; j < LINE_WIDTH; j++) begin
						line_buf[pos] = line_buf[j];
						pos++;
					end
				end
			end
			if (char_run.size() > 0) begin
				b = char_run.pop_back();
				b.last = 1'b1;
				char_run.push_back(b);
			end
			foreach (char_run[i])
				folded_text.push_back(char_run[i]);
			column = pos;
		endfunction

		function void check_beat(input logic [7:0] ch, input logic lst);
			fold_beat_t want;
			if (folded_text.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual char_out=%h last=%b",
					$time, ch, lst);
				errors++;
				return;
			end
			want = folded_text.pop_front();
			if (ch !== want.ch) begin
				$display("%0t: char_out mismatch: expected %h, actual %h", $time, want.ch, ch);
				errors++;
			end
			if (lst !== want.last) begin
				$display("%0t: last mismatch: expected %b, actual %b", $time, want.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] tab_shift;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_in;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] char_out;
	logic       last;

	line_fold_predictor predictor = new();
	int  long_run = 0;
	bit  send_steady = 1'b0;
	int  idle_cycles = 0;

	text_line_folder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.tab_shift (tab_shift),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_in   (char_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_out  (char_out),
		.last      (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		do @(posedge clk); while (!in_ready);
		predictor.take_char(c);
		if ($urandom_range(0, 29) == 0)
			send_steady = !send_steady;
	endtask

	task automatic write_tab_shift(input logic [1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		tab_shift <= v;
		do @(posedge clk); while (!cfg_ready);
		predictor.set_tab_shift(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A tab or plain byte may still be in work after the last expected beat.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (predictor.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly words and blanks so lines fold often; now and then a long run
	// of 61 to 76 non-blank bytes, and some raw bytes.
	function automatic logic [7:0] next_text_char();
		int r;
		if (long_run > 0) begin
			long_run--;
			return 8'($urandom_range(33, 126));
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			long_run = $urandom_range(60, 75);
			return 8'($urandom_range(33, 126));
		end
		if (r < 58)
			return 8'($urandom_range(33, 126));
		if (r < 74)
			return CH_BLANK;
		if (r < 81)
			return CH_TAB;
		if (r < 86)
			return CH_NL;
		return 8'($urandom_range(0, 255));
	endfunction

	// Receiver: one stall draw per beat, plus one long hold so the block backs up.
	initial begin
		int gap;
		int beats_seen;
		bit held;
		bit recv_steady;
		beats_seen = 0;
		held = 1'b0;
		recv_steady = 1'b0;
		out_ready = 1'b0;
		forever begin
			gap = recv_steady ? 0 : $urandom_range(0, 5);
			if (!held && beats_seen >= PRESSURE_AFTER_BEATS) begin
				gap = PRESSURE_CYCLES;
				held = 1'b1;
			end
			@(negedge clk);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			predictor.check_beat(char_out, last);
			beats_seen++;
			if ($urandom_range(0, 29) == 0)
				recv_steady = !recv_steady;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [1:0] phase_shift [4];
		phase_shift = '{2'd0, 2'd2, 2'd1, 2'd3};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		tab_shift = TAB_SHIFT_RST;
		in_valid = 1'b0;
		char_in = 8'd0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Widest tab stops reach the last column in few bytes.
		write_tab_shift(2'd3);

		// Blank in the last column: cut at full width, nothing carried over.
		repeat (7) send_char(CH_TAB);
		send_char(8'h00);
		send_char(8'hFF);
		send_char("a");
		send_char("b");
		send_char("c");
		send_char("d");
		send_char(CH_BLANK);
		// Empty line gives nothing.
		send_char(CH_NL);
		// Tab at the last column becomes one blank and ends the line.
		repeat (7) send_char(CH_TAB);
		send_char("Z");
		send_char("Y");
		send_char("X");
		send_char("W");
		send_char("V");
		send_char("U");
		send_char(CH_TAB);
		send_char("q");
		send_char(CH_NL);

		foreach (phase_shift[k]) begin
			wait_idle();
			write_tab_shift(phase_shift[k]);
			repeat (ITEMS_PER_PHASE) send_char(next_text_char());
		end

		wait_idle();
		if (predictor.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
